// File: src/tcg_pkg.sv
package tcg_pkg;

  localparam int WORD_WIDTH = 64;
  localparam int FRAC_BITS  = 40;
  localparam int CFG_WIDTH  = 63;
  localparam int ADDR_W     = 5;
  localparam int PC_W       = 7;

  localparam logic [PC_W-1:0] PROG_LAST = 7'd79;

  localparam logic [CFG_WIDTH-1:0] GM_RESET = 63'd21990232555520;
  localparam logic [CFG_WIDTH-1:0] DT_RESET = 63'd1099511628;

  localparam logic [1:0] CFG_GM        = 2'd0;
  localparam logic [1:0] CFG_HALF_SEP  = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP = 2'd2;

  // Register file map.
  localparam logic [ADDR_W-1:0] A_CX  = 5'd0;
  localparam logic [ADDR_W-1:0] A_CY  = 5'd1;
  localparam logic [ADDR_W-1:0] A_CVX = 5'd2;
  localparam logic [ADDR_W-1:0] A_CVY = 5'd3;
  localparam logic [ADDR_W-1:0] A_GM  = 5'd4;
  localparam logic [ADDR_W-1:0] A_HS  = 5'd5;
  localparam logic [ADDR_W-1:0] A_DT  = 5'd6;
  localparam logic [ADDR_W-1:0] A_ZR  = 5'd7;
  localparam logic [ADDR_W-1:0] A_SX  = 5'd8;
  localparam logic [ADDR_W-1:0] A_SY  = 5'd9;
  localparam logic [ADDR_W-1:0] A_NHS = 5'd10;
  localparam logic [ADDR_W-1:0] A_DX  = 5'd11;
  localparam logic [ADDR_W-1:0] A_T1  = 5'd12;
  localparam logic [ADDR_W-1:0] A_T2  = 5'd13;
  localparam logic [ADDR_W-1:0] A_R2  = 5'd14;
  localparam logic [ADDR_W-1:0] A_R3  = 5'd15;
  localparam logic [ADDR_W-1:0] A_AX0 = 5'd16;
  localparam logic [ADDR_W-1:0] A_AY0 = 5'd17;
  localparam logic [ADDR_W-1:0] A_AX1 = 5'd18;
  localparam logic [ADDR_W-1:0] A_AY1 = 5'd19;
  localparam logic [ADDR_W-1:0] A_PX  = 5'd20;
  localparam logic [ADDR_W-1:0] A_PY  = 5'd21;
  localparam logic [ADDR_W-1:0] A_NVX = 5'd22;
  localparam logic [ADDR_W-1:0] A_NVY = 5'd23;

  typedef enum logic [2:0] {
    OP_ADD, OP_NEG, OP_HALF, OP_MUL, OP_DIV, OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

  typedef struct packed {
    alu_op_t           op;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } uop_t;

  function automatic uop_t mk(input alu_op_t op, input logic [ADDR_W-1:0] d,
                              input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b);
    uop_t u;
    u.op = op;
    u.dst = d;
    u.a = a;
    u.b = b;
    return u;
  endfunction

  // Acceleration at (xr, yr) into (axr, ayr), 27 micro-operations.
  function automatic uop_t accel_uop(input logic [PC_W-1:0] k,
                                     input logic [ADDR_W-1:0] xr, input logic [ADDR_W-1:0] yr,
                                     input logic [ADDR_W-1:0] axr,
                                     input logic [ADDR_W-1:0] ayr);
    uop_t u;
    case (k)
      7'd0:         u = mk(OP_ADD, A_SX, A_ZR, A_ZR);
      7'd1:         u = mk(OP_ADD, A_SY, A_ZR, A_ZR);
      7'd2:         u = mk(OP_NEG, A_NHS, A_HS, A_HS);
      7'd3:         u = mk(OP_ADD, A_DX, xr, A_NHS);
      7'd4, 7'd14:  u = mk(OP_MUL, A_T1, A_DX, A_DX);
      7'd5, 7'd15:  u = mk(OP_MUL, A_T2, yr, yr);
      7'd6, 7'd16:  u = mk(OP_ADD, A_R2, A_T1, A_T2);
      7'd7, 7'd17:  u = mk(OP_SQRT, A_T1, A_R2, A_R2);
      7'd8, 7'd18:  u = mk(OP_MUL, A_R3, A_R2, A_T1);
      7'd9, 7'd19:  u = mk(OP_DIV, A_T2, A_DX, A_R3);
      7'd10, 7'd20: u = mk(OP_ADD, A_SX, A_SX, A_T2);
      7'd11, 7'd21: u = mk(OP_DIV, A_T2, yr, A_R3);
      7'd12, 7'd22: u = mk(OP_ADD, A_SY, A_SY, A_T2);
      7'd13:        u = mk(OP_ADD, A_DX, xr, A_HS);
      7'd23:        u = mk(OP_MUL, A_T1, A_GM, A_SX);
      7'd24:        u = mk(OP_NEG, axr, A_T1, A_T1);
      7'd25:        u = mk(OP_MUL, A_T1, A_GM, A_SY);
      7'd26:        u = mk(OP_NEG, ayr, A_T1, A_T1);
      default:      u = mk(OP_ADD, A_ZR, A_ZR, A_ZR);
    endcase
    return u;
  endfunction

  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    if (pc < 7'd27) begin
      u = accel_uop(pc, A_CX, A_CY, A_AX0, A_AY0);
    end else if (pc >= 7'd35 && pc < 7'd62) begin
      u = accel_uop(pc - 7'd35, A_PX, A_PY, A_AX1, A_AY1);
    end else begin
      case (pc)
        7'd27:   u = mk(OP_MUL, A_T1, A_AX0, A_DT);
        7'd28:   u = mk(OP_ADD, A_T1, A_CVX, A_T1);
        7'd29:   u = mk(OP_MUL, A_T1, A_T1, A_DT);
        7'd30:   u = mk(OP_ADD, A_PX, A_CX, A_T1);
        7'd31:   u = mk(OP_MUL, A_T1, A_AY0, A_DT);
        7'd32:   u = mk(OP_ADD, A_T1, A_CVY, A_T1);
        7'd33:   u = mk(OP_MUL, A_T1, A_T1, A_DT);
        7'd34:   u = mk(OP_ADD, A_PY, A_CY, A_T1);
        7'd62:   u = mk(OP_ADD, A_T1, A_AX0, A_AX1);
        7'd63:   u = mk(OP_HALF, A_T1, A_T1, A_T1);
        7'd64:   u = mk(OP_MUL, A_T1, A_T1, A_DT);
        7'd65:   u = mk(OP_ADD, A_NVX, A_CVX, A_T1);
        7'd66:   u = mk(OP_ADD, A_T1, A_AY0, A_AY1);
        7'd67:   u = mk(OP_HALF, A_T1, A_T1, A_T1);
        7'd68:   u = mk(OP_MUL, A_T1, A_T1, A_DT);
        7'd69:   u = mk(OP_ADD, A_NVY, A_CVY, A_T1);
        7'd70:   u = mk(OP_ADD, A_T1, A_NVX, A_CVX);
        7'd71:   u = mk(OP_HALF, A_T1, A_T1, A_T1);
        7'd72:   u = mk(OP_MUL, A_T1, A_T1, A_DT);
        7'd73:   u = mk(OP_ADD, A_CX, A_CX, A_T1);
        7'd74:   u = mk(OP_ADD, A_T1, A_NVY, A_CVY);
        7'd75:   u = mk(OP_HALF, A_T1, A_T1, A_T1);
        7'd76:   u = mk(OP_MUL, A_T1, A_T1, A_DT);
        7'd77:   u = mk(OP_ADD, A_CY, A_CY, A_T1);
        7'd78:   u = mk(OP_ADD, A_CVX, A_NVX, A_ZR);
        7'd79:   u = mk(OP_ADD, A_CVY, A_NVY, A_ZR);
        default: u = mk(OP_ADD, A_ZR, A_ZR, A_ZR);
      endcase
    end
    return u;
  endfunction

endpackage

// File: src/tcg_alu.sv
module tcg_alu #(
  parameter int W = tcg_pkg::WORD_WIDTH,
  parameter int F = tcg_pkg::FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tcg_pkg::alu_req_t      req,
  input  logic signed [W-1:0]    a,
  input  logic signed [W-1:0]    b,
  output tcg_pkg::alu_rsp_t      rsp,
  output logic signed [W-1:0]    res
);

  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;
  localparam int MW = 2 * W + 2;
  localparam int CW = $clog2(W);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_SQRT, A_FIN} ast_t;

  ast_t             st;
  tcg_pkg::alu_op_t op_r;
  logic             neg_r;
  logic             done;
  logic             sat_r;
  logic [PW-1:0]    acc;
  logic [W+1:0]     rem;
  logic [W-1:0]     sh;
  logic [CW-1:0]    cnt;

  logic [W-1:0]     ma, mb, hm, half_res, add_res, nh;
  logic [W:0]       sum;
  logic             add_sat;
  logic [2*H-1:0]   pa, pb, prod;
  logic [H-1:0]     pah, pbh;
  logic [PW-1:0]    term;
  logic [W:0]       dtr, ddiff;
  logic             dge;
  logic [W+3:0]     str, trial, sdiff;
  logic             sge;
  logic [MW-1:0]    fin_mag;
  logic [W:0]       fin;

  function automatic logic [W:0] from_sm(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [MW-1:0] tmp;
    lim = MW'(MAXV) + MW'(neg);
    tmp = ~m + MW'(1);
    if (m > lim) begin
      return {1'b1, (neg ? MINV : MAXV)};
    end else if (neg) begin
      return {1'b0, tmp[W-1:0]};
    end
    return {1'b0, m[W-1:0]};
  endfunction

  assign ma = a[W-1] ? (~a + 1'b1) : a;
  assign mb = b[W-1] ? (~b + 1'b1) : b;
  assign sum = {a[W-1], a} + {b[W-1], b};
  assign add_sat = sum[W] != sum[W-1];
  assign add_res = add_sat ? (sum[W] ? MINV : MAXV) : sum[W-1:0];
  assign hm = ma >> 1;
  assign half_res = a[W-1] ? (~hm + 1'b1) : hm;
  assign nh = ma >> (W - F);

  assign pa = (2*H)'(ma);
  assign pb = (2*H)'(mb);
  assign pah = cnt[1] ? pa[2*H-1:H] : pa[H-1:0];
  assign pbh = cnt[0] ? pb[2*H-1:H] : pb[H-1:0];
  assign prod = pah * pbh;

  always_comb begin
    case (cnt[1:0])
      2'd0:    term = PW'(prod);
      2'd3:    term = PW'(prod) << (2 * H);
      default: term = PW'(prod) << H;
    endcase
  end

  assign dtr = {rem[W-1:0], sh[W-1]};
  assign dge = dtr >= {1'b0, mb};
  assign ddiff = dtr - {1'b0, mb};

  assign str = {rem, acc[2*W-1 -: 2]};
  assign trial = {2'b00, sh, 2'b01};
  assign sge = str >= trial;
  assign sdiff = str - trial;

  assign fin_mag = (op_r == tcg_pkg::OP_MUL) ? MW'(acc >> F) : MW'(sh);
  assign fin = from_sm(neg_r, fin_mag);

  assign rsp.done = done;
  assign rsp.sat = sat_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= A_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        A_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            neg_r <= (a[W-1] ^ b[W-1]) && (req.op != tcg_pkg::OP_SQRT);
            cnt <= '0;
            case (req.op)
              tcg_pkg::OP_ADD: begin
                res <= add_res;
                sat_r <= add_sat;
                done <= 1'b1;
              end
              tcg_pkg::OP_NEG: begin
                res <= (a == MINV) ? MAXV : (~a + 1'b1);
                sat_r <= a == MINV;
                done <= 1'b1;
              end
              tcg_pkg::OP_HALF: begin
                res <= half_res;
                sat_r <= 1'b0;
                done <= 1'b1;
              end
              tcg_pkg::OP_MUL: begin
                acc <= '0;
                st <= A_MUL;
              end
              tcg_pkg::OP_DIV: begin
                if (b == '0) begin
                  res <= a[W-1] ? MINV : MAXV;
                  sat_r <= 1'b1;
                  done <= 1'b1;
                end else if (nh >= mb) begin
                  res <= (a[W-1] ^ b[W-1]) ? MINV : MAXV;
                  sat_r <= 1'b1;
                  done <= 1'b1;
                end else begin
                  rem <= (W+2)'(nh);
                  sh <= ma << F;
                  st <= A_DIV;
                end
              end
              tcg_pkg::OP_SQRT: begin
                if (a[W-1] || a == '0) begin
                  res <= '0;
                  sat_r <= 1'b0;
                  done <= 1'b1;
                end else begin
                  acc <= PW'(ma) << F;
                  rem <= '0;
                  sh <= '0;
                  st <= A_SQRT;
                end
              end
              default: begin
                res <= '0;
                sat_r <= 1'b0;
                done <= 1'b1;
              end
            endcase
          end
        end
        A_MUL: begin
          acc <= acc + term;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(3)) st <= A_FIN;
        end
        A_DIV: begin
          rem <= (W+2)'(dge ? ddiff[W-1:0] : dtr[W-1:0]);
          sh <= {sh[W-2:0], dge};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) st <= A_FIN;
        end
        A_SQRT: begin
          rem <= (W+2)'(sge ? sdiff : str);
          sh <= {sh[W-2:0], sge};
          acc <= acc << 2;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) st <= A_FIN;
        end
        A_FIN: begin
          res <= fin[W-1:0];
          sat_r <= fin[W];
          done <= 1'b1;
          st <= A_IDLE;
        end
        default: st <= A_IDLE;
      endcase
    end
  end

endmodule

// File: src/two_center_gravity_heun_step_unit.sv
// A load transaction writes the four clamped load words into the register file,
// then reads them back as the result. A step transaction runs an 80-operation
// sequence on one shared arithmetic unit; early exits shorten it. Division and
// square root each take one bit per cycle. One transaction is in flight at a time;
// the next is accepted once the result shows. Synchronous reset rewrites register
// entries 0 to 7 with zero or the gravity and time-step defaults, not ready meanwhile.
module two_center_gravity_heun_step_unit #(
  parameter int WORD_WIDTH = tcg_pkg::WORD_WIDTH,
  parameter int FRAC_BITS  = tcg_pkg::FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,   // load_x, load_y, load_vx, load_vy
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y
  output logic         m_tuser,   // singular
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [62:0]  cfg_data
);

  localparam int W  = WORD_WIDTH;
  localparam int AW = tcg_pkg::ADDR_W;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_WAIT, S_DONE, S_READ
  } state_t;

  state_t                  state;
  logic [2:0]              cnt;
  logic [tcg_pkg::PC_W-1:0] pc;
  tcg_pkg::uop_t           uop;
  logic [63:0]             ld_x, ld_y, ld_vx, ld_vy;
  logic                    sat_acc;

  logic signed [W-1:0]     rf [2**AW];
  logic signed [W-1:0]     rd_a, rd_b;
  logic [AW-1:0]           raddr_a, raddr_b, waddr;
  logic                    we;
  logic signed [W-1:0]     wdata;

  tcg_pkg::alu_req_t       req;
  tcg_pkg::alu_rsp_t       rsp;
  logic signed [W-1:0]     alu_res;

  function automatic logic [W-1:0] clamp_cfg(input logic [62:0] v);
    if ({1'b0, v} > 64'(MAXV)) return MAXV;
    return W'(v);
  endfunction

  function automatic logic [W-1:0] clamp_in(input logic [63:0] v);
    if ($signed(v) > $signed(64'(MAXV))) return MAXV;
    if ($signed(v) < $signed(~64'(MAXV))) return ~MAXV;
    return W'(v);
  endfunction

  assign uop = tcg_pkg::prog(pc);
  assign s_tready = state == S_IDLE;
  assign cfg_ready = state == S_IDLE;
  assign req.start = state == S_EXEC;
  assign req.op = uop.op;

  assign raddr_a = (state == S_READ) ? (tcg_pkg::A_CX + AW'(cnt)) : uop.a;
  assign raddr_b = uop.b;

  always_comb begin
    we = 1'b0;
    waddr = tcg_pkg::A_ZR;
    wdata = '0;
    case (state)
      S_INIT: begin
        we = 1'b1;
        waddr = AW'(cnt);
        if (AW'(cnt) == tcg_pkg::A_GM) wdata = clamp_cfg(tcg_pkg::GM_RESET);
        else if (AW'(cnt) == tcg_pkg::A_DT) wdata = clamp_cfg(tcg_pkg::DT_RESET);
      end
      S_IDLE: begin
        wdata = clamp_cfg(cfg_data);
        case (cfg_index)
          tcg_pkg::CFG_GM: begin
            we = cfg_valid;
            waddr = tcg_pkg::A_GM;
          end
          tcg_pkg::CFG_HALF_SEP: begin
            we = cfg_valid;
            waddr = tcg_pkg::A_HS;
          end
          tcg_pkg::CFG_TIME_STEP: begin
            we = cfg_valid;
            waddr = tcg_pkg::A_DT;
          end
          default: we = 1'b0;
        endcase
      end
      S_LOAD: begin
        we = 1'b1;
        waddr = tcg_pkg::A_CX + AW'(cnt);
        case (cnt[1:0])
          2'd0:    wdata = clamp_in(ld_x);
          2'd1:    wdata = clamp_in(ld_y);
          2'd2:    wdata = clamp_in(ld_vx);
          default: wdata = clamp_in(ld_vy);
        endcase
      end
      S_WAIT: begin
        we = rsp.done;
        waddr = uop.dst;
        wdata = alu_res;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) rf[waddr] <= wdata;
    rd_a <= rf[raddr_a];
    rd_b <= rf[raddr_b];
  end

  tcg_alu #(.W(W), .F(FRAC_BITS)) u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .a   (rd_a),
    .b   (rd_b),
    .rsp (rsp),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
      pc <= '0;
      sat_acc <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd7) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            ld_x <= s_tdata[63:0];
            ld_y <= s_tdata[127:64];
            ld_vx <= s_tdata[191:128];
            ld_vy <= s_tdata[255:192];
            sat_acc <= 1'b0;
            cnt <= '0;
            pc <= '0;
            state <= s_tuser ? S_FETCH : S_LOAD;
          end
        end
        S_LOAD: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd3) state <= S_DONE;
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC:  state <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            sat_acc <= sat_acc | rsp.sat;
            if (pc == tcg_pkg::PROG_LAST) begin
              state <= S_DONE;
            end else begin
              pc <= pc + 1'b1;
              state <= S_FETCH;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid) begin
            cnt <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          cnt <= cnt + 1'b1;
          case (cnt)
            3'd1:    m_tdata[63:0] <= 64'(rd_a);
            3'd2:    m_tdata[127:64] <= 64'(rd_a);
            3'd3:    m_tdata[191:128] <= 64'(rd_a);
            3'd4: begin
              m_tdata[255:192] <= 64'(rd_a);
              m_tuser <= sat_acc;
              m_tvalid <= 1'b1;
              state <= S_IDLE;
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/tcg_checker.sv
module tcg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [255:0] m_tdata,
  input logic         m_tuser,
  input logic         cfg_ready
);

  // The block takes one transaction and then works on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted transaction");

  a_ready_pair: assert property (@(posedge clk) disable iff (rst)
    s_tready == cfg_ready)
    else $error("input and configuration ready disagree");

  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result shown while the block is still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind two_center_gravity_heun_step_unit tcg_checker u_tcg_checker (.*);
